// ===== sv/itf_pkg.sv =====
// Shared types, constants and helpers for the integer-to-text formatter.
// No dependencies; every other file of the block imports this package.
package itf_pkg;

    localparam int VALUE_W         = 64;
    localparam int MODE_W          = 3;
    localparam int CHAR_W          = 8;
    localparam int DIGIT_W         = 4;
    localparam int BYTE_W          = 8;
    localparam int NUM_CELLS       = 20;
    localparam int HEX_DIGITS      = VALUE_W / DIGIT_W;
    localparam int DEC_BYTE_DIGITS = 3;
    localparam int HEX_BYTE_DIGITS = BYTE_W / DIGIT_W;
    localparam int IPV4_BYTES      = 4;
    localparam int MAC_BYTES       = 6;
    localparam int IDX_W           = $clog2(NUM_CELLS);
    localparam int LEFT_W          = $clog2(NUM_CELLS + 1);
    localparam int STEP_W          = $clog2(VALUE_W + 1);
    localparam int SEG_W           = $clog2(MAC_BYTES);

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_A     = 8'h61;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2e;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3a;

    typedef enum logic [MODE_W-1:0] {
        MODE_HEX     = 3'd0,
        MODE_HEX_PAD = 3'd1,
        MODE_UDEC    = 3'd2,
        MODE_SDEC    = 3'd3,
        MODE_IPV4    = 3'd4,
        MODE_MAC     = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_DABBLE
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     serial_bit;
    } t_chain_ctrl;

    typedef logic [NUM_CELLS-1:0][DIGIT_W-1:0] t_digits;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SIGN,
        ST_LOAD,
        ST_CONV,
        ST_DIGIT,
        ST_SEP
    } t_state;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] w_d;
        w_d = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (d < DIGIT_W'(10)) begin
            return CH_ZERO + w_d;
        end
        return CH_A + w_d - CHAR_W'(10);
    endfunction

endpackage

// ===== sv/itf_in_if.sv =====
// Input channel of the formatter: mode and 64-bit value with valid/ready.
// Depends on itf_pkg for the field widths.
interface itf_in_if import itf_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [MODE_W-1:0]    action;
    logic [VALUE_W-1:0]   value;

    modport source(output valid, action, value, input ready);
    modport sink(input valid, action, value, output ready);
endinterface

// ===== sv/itf_out_if.sv =====
// Output channel of the formatter: one character and a last flag per item.
// Depends on itf_pkg for the field widths.
interface itf_out_if import itf_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CHAR_W-1:0]   out_char;
    logic                last;

    modport source(output valid, out_char, last, input ready);
    modport sink(input valid, out_char, last, output ready);
endinterface

// ===== sv/itf_cell.sv =====
// One digit cell: holds a 4-bit digit, loads it, or does one shift-and-add-3 step.
// Depends on itf_pkg.
module itf_cell import itf_pkg::*; (
    input  logic               i_clk,
    input  t_cell_op           i_op,
    input  logic [DIGIT_W-1:0] i_load_digit,
    input  logic               i_bit,
    output logic               o_bit,
    output logic [DIGIT_W-1:0] o_digit
);

    logic [DIGIT_W-1:0] r_digit;
    logic [DIGIT_W-1:0] n_digit;
    logic [DIGIT_W-1:0] w_adj;

    assign w_adj   = (r_digit >= DIGIT_W'(5)) ? r_digit + DIGIT_W'(3) : r_digit;
    assign o_bit   = w_adj[DIGIT_W-1];
    assign o_digit = r_digit;

    always_comb begin
        unique case (i_op)
            CELL_HOLD:   n_digit = r_digit;
            CELL_LOAD:   n_digit = i_load_digit;
            CELL_DABBLE: n_digit = {w_adj[DIGIT_W-2:0], i_bit};
            default:     n_digit = r_digit;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

// ===== sv/itf_chain.sv =====
// Row of digit cells; the serial bit enters the lowest cell and carries ripple upward.
// Depends on itf_pkg and itf_cell.
module itf_chain import itf_pkg::*; (
    input  logic        i_clk,
    input  t_chain_ctrl i_ctrl,
    input  t_digits     i_load,
    output t_digits     o_digits
);

    logic [NUM_CELLS:0] w_link;

    assign w_link[0] = i_ctrl.serial_bit;

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        itf_cell u_cell (
            .i_clk        (i_clk),
            .i_op         (i_ctrl.op),
            .i_load_digit (i_load[g]),
            .i_bit        (w_link[g]),
            .o_bit        (w_link[g+1]),
            .o_digit      (o_digits[g])
        );
    end

endmodule

// ===== sv/integer_to_text_formatter_unit.sv =====
// Decimal modes: accept, load, one conversion step per value bit, then the digit cells,
// plus a state for the minus sign of a negative value.
// IPv4 loads, converts and emits digits per byte; hex loads then emits digits; MAC loads and emits per byte.
// The conversion time is set by the bit-serial digit cell row; one item at a time.
// Reset (synchronous, active low) empties the output register and returns to idle.
// Depends on itf_pkg, itf_in_if, itf_out_if and itf_chain.
module integer_to_text_formatter_unit import itf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    itf_in_if.sink    i_in,
    itf_out_if.source o_out
);

    t_state              r_state, n_state;
    t_mode               r_mode, n_mode;
    logic [VALUE_W-1:0]  r_val, n_val;
    logic [VALUE_W-1:0]  r_bits, n_bits;
    logic [STEP_W-1:0]   r_steps, n_steps;
    logic [LEFT_W-1:0]   r_left, n_left;
    logic [SEG_W-1:0]    r_seg, n_seg;
    logic                r_started, n_started;
    logic                r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]   r_out_char, n_out_char;
    logic                r_out_last, n_out_last;

    t_chain_ctrl         w_ctrl;
    t_digits             w_load;
    t_digits             w_digits;
    t_mode               w_in_mode;
    logic [IDX_W-1:0]    w_idx;
    logic [DIGIT_W-1:0]  w_digit;
    logic [SEG_W-1:0]    w_last_seg;
    logic                w_final_seg;
    logic                w_can_emit;
    logic                w_in_acc;
    logic                w_emit;
    logic [CHAR_W-1:0]   w_char;
    logic                w_last;

    itf_chain u_chain (
        .i_clk    (i_clk),
        .i_ctrl   (w_ctrl),
        .i_load   (w_load),
        .o_digits (w_digits)
    );

    assign i_in.ready     = (r_state == ST_IDLE);
    assign w_in_acc       = i_in.valid && i_in.ready;
    assign o_out.valid    = r_out_valid;
    assign o_out.out_char = r_out_char;
    assign o_out.last     = r_out_last;

    assign w_can_emit  = !r_out_valid || o_out.ready;
    assign w_idx       = IDX_W'(r_left - LEFT_W'(1));
    assign w_digit     = w_digits[w_idx];
    assign w_final_seg = (r_seg == w_last_seg);

    always_comb begin
        unique case (t_mode'(i_in.action))
            MODE_HEX_PAD: w_in_mode = MODE_HEX_PAD;
            MODE_UDEC:    w_in_mode = MODE_UDEC;
            MODE_SDEC:    w_in_mode = MODE_SDEC;
            MODE_IPV4:    w_in_mode = MODE_IPV4;
            MODE_MAC:     w_in_mode = MODE_MAC;
            default:      w_in_mode = MODE_HEX;
        endcase
    end

    always_comb begin
        unique case (r_mode)
            MODE_IPV4: w_last_seg = SEG_W'(IPV4_BYTES - 1);
            MODE_MAC:  w_last_seg = SEG_W'(MAC_BYTES - 1);
            default:   w_last_seg = '0;
        endcase
    end

    always_comb begin
        w_load = '0;
        unique case (r_mode)
            MODE_HEX, MODE_HEX_PAD: begin
                for (int i = 0; i < HEX_DIGITS; i++) begin
                    w_load[i] = r_val[i*DIGIT_W +: DIGIT_W];
                end
            end
            MODE_MAC: begin
                for (int i = 0; i < HEX_BYTE_DIGITS; i++) begin
                    w_load[i] = r_val[i*DIGIT_W +: DIGIT_W];
                end
            end
            default: w_load = '0;
        endcase
    end

    always_comb begin
        n_state           = r_state;
        n_mode            = r_mode;
        n_val             = r_val;
        n_bits            = r_bits;
        n_steps           = r_steps;
        n_left            = r_left;
        n_seg             = r_seg;
        n_started         = r_started;
        w_ctrl.op         = CELL_HOLD;
        w_ctrl.serial_bit = r_bits[VALUE_W-1];
        w_emit            = 1'b0;
        w_char            = CH_ZERO;
        w_last            = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_mode = w_in_mode;
                    n_seg  = '0;
                    if (w_in_mode == MODE_SDEC && i_in.value[VALUE_W-1]) begin
                        n_val   = ~i_in.value + VALUE_W'(1);
                        n_state = ST_SIGN;
                    end else begin
                        n_val   = i_in.value;
                        n_state = ST_LOAD;
                    end
                end
            end
            ST_SIGN: begin
                if (w_can_emit) begin
                    w_emit  = 1'b1;
                    w_char  = CH_MINUS;
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                w_ctrl.op = CELL_LOAD;
                n_started = (r_mode == MODE_HEX_PAD);
                unique case (r_mode)
                    MODE_UDEC, MODE_SDEC: begin
                        n_bits  = r_val;
                        n_steps = STEP_W'(VALUE_W);
                        n_left  = LEFT_W'(NUM_CELLS);
                        n_state = ST_CONV;
                    end
                    MODE_IPV4: begin
                        n_bits  = {r_val[BYTE_W-1:0], {(VALUE_W-BYTE_W){1'b0}}};
                        n_steps = STEP_W'(BYTE_W);
                        n_left  = LEFT_W'(DEC_BYTE_DIGITS);
                        n_state = ST_CONV;
                    end
                    MODE_MAC: begin
                        n_left  = LEFT_W'(HEX_BYTE_DIGITS);
                        n_state = ST_DIGIT;
                    end
                    default: begin
                        n_left  = LEFT_W'(HEX_DIGITS);
                        n_state = ST_DIGIT;
                    end
                endcase
            end
            ST_CONV: begin
                w_ctrl.op = CELL_DABBLE;
                n_bits    = {r_bits[VALUE_W-2:0], 1'b0};
                n_steps   = r_steps - STEP_W'(1);
                if (r_steps == STEP_W'(1)) begin
                    n_state = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (!r_started && w_digit == '0 && r_left > LEFT_W'(1)) begin
                    n_left = r_left - LEFT_W'(1);
                end else if (w_can_emit) begin
                    w_emit = 1'b1;
                    w_char = digit_char(w_digit);
                    if (r_left == LEFT_W'(1)) begin
                        w_last = w_final_seg;
                        if (w_final_seg) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_seg   = r_seg + SEG_W'(1);
                            n_val   = r_val >> BYTE_W;
                            n_state = ST_SEP;
                        end
                    end else begin
                        n_left    = r_left - LEFT_W'(1);
                        n_started = 1'b1;
                    end
                end
            end
            ST_SEP: begin
                if (w_can_emit) begin
                    w_emit  = 1'b1;
                    w_char  = (r_mode == MODE_IPV4) ? CH_DOT : CH_COLON;
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        if (w_emit) begin
            n_out_valid = 1'b1;
            n_out_char  = w_char;
            n_out_last  = w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_val      <= n_val;
        r_bits     <= n_bits;
        r_steps    <= n_steps;
        r_left     <= n_left;
        r_seg      <= n_seg;
        r_started  <= n_started;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

`ifndef SYNTHESIS
    a_conv_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CONV |-> r_steps != '0)
        else $error("Conversion running with no steps left.");

    a_conv_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CONV |->
            (r_mode == MODE_UDEC || r_mode == MODE_SDEC || r_mode == MODE_IPV4))
        else $error("Decimal conversion entered in a hex mode.");

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIGIT |-> (r_left != '0 && r_left <= LEFT_W'(NUM_CELLS)))
        else $error("Digit index outside the cell row.");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_state != ST_IDLE)
        else $error("Accepted item did not start work.");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_last) |=> (r_state == ST_IDLE && r_out_valid && r_out_last))
        else $error("Last character did not end the item.");
`endif

endmodule

// ===== sim/itf_text_checker.sv =====
// Passive checker for the integer-to-text formatter: predicts the text of each accepted item.
// It compares every output character with that text and reports failures.
// Depends on itf_pkg, itf_in_if and itf_out_if.
module itf_text_checker import itf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    itf_in_if    i_in,
    itf_out_if   i_out,
    output int   o_fail_count,
    output int   o_chars_left
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_text_char;

    t_text_char        text_expected[$];
    logic [CHAR_W-1:0] render_buf[$];
    t_text_char        want;
    int                mismatch_total = 0;
    int                chars_left     = 0;

    assign o_fail_count = mismatch_total;
    assign o_chars_left = chars_left;

    function automatic logic [CHAR_W-1:0] nibble_char(logic [DIGIT_W-1:0] d);
        if (d >= DIGIT_W'(10)) begin
            return CH_A + CHAR_W'(d - DIGIT_W'(10));
        end
        return CH_ZERO + CHAR_W'(d);
    endfunction

    function automatic void put_hex(logic [VALUE_W-1:0] v, int ndig, bit pad);
        logic [DIGIT_W-1:0] d;
        for (int i = ndig - 1; i >= 0; i--) begin
            d = v[DIGIT_W*i +: DIGIT_W];
            if (d != '0 || pad || i == 0) begin
                pad = 1'b1;
                render_buf.push_back(nibble_char(d));
            end
        end
    endfunction

    function automatic void put_dec(logic [VALUE_W-1:0] v);
        logic [CHAR_W-1:0] digs[$];
        do begin
            digs.push_front(CH_ZERO + CHAR_W'(v % VALUE_W'(10)));
            v = v / VALUE_W'(10);
        end while (v != '0);
        foreach (digs[i]) begin
            render_buf.push_back(digs[i]);
        end
    endfunction

    function automatic void render_text(logic [MODE_W-1:0] action, logic [VALUE_W-1:0] value);
        t_text_char tc;
        render_buf.delete();
        case (action)
            MODE_HEX_PAD: put_hex(value, HEX_DIGITS, 1'b1);
            MODE_UDEC:    put_dec(value);
            MODE_SDEC: begin
                if (value[VALUE_W-1]) begin
                    render_buf.push_back(CH_MINUS);
                    put_dec(VALUE_W'(0) - value);
                end else begin
                    put_dec(value);
                end
            end
            MODE_IPV4: begin
                for (int i = 0; i < IPV4_BYTES; i++) begin
                    if (i > 0) begin
                        render_buf.push_back(CH_DOT);
                    end
                    put_dec(VALUE_W'(value[BYTE_W*i +: BYTE_W]));
                end
            end
            MODE_MAC: begin
                for (int i = 0; i < MAC_BYTES; i++) begin
                    if (i > 0) begin
                        render_buf.push_back(CH_COLON);
                    end
                    put_hex(VALUE_W'(value[BYTE_W*i +: BYTE_W]), HEX_BYTE_DIGITS, 1'b0);
                end
            end
            default: put_hex(value, HEX_DIGITS, 1'b0);
        endcase
        foreach (render_buf[i]) begin
            tc.ch   = render_buf[i];
            tc.last = (i == render_buf.size() - 1);
            text_expected.push_back(tc);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_out.valid && i_out.ready) begin
                if (text_expected.size() == 0) begin
                    mismatch_total++;
                    if (mismatch_total <= REPORT_LIMIT) begin
                        $display("%t: unexpected char %h last %b", $realtime,
                                 i_out.out_char, i_out.last);
                    end
                end else begin
                    want = text_expected.pop_front();
                    if (i_out.out_char !== want.ch || i_out.last !== want.last) begin
                        mismatch_total++;
                        if (mismatch_total <= REPORT_LIMIT) begin
                            $display("%t: expected char %h last %b, got char %h last %b",
                                     $realtime, want.ch, want.last, i_out.out_char, i_out.last);
                        end
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                render_text(i_in.action, i_in.value);
            end
            chars_left <= text_expected.size();
        end
    end

endmodule

// ===== sim/integer_to_text_formatter_unit_test.sv =====
// Top of the formatter testbench: clock, reset, input items in bursts, output stalls.
// Depends on itf_pkg, itf_in_if, itf_out_if, itf_text_checker and the formatter block.
module integer_to_text_formatter_unit_test import itf_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
    localparam int RANDOM_ITEMS  = 146;
    localparam int HOLD_CYCLES   = 600;
    localparam int HOLD_SEGMENT  = 10;
    localparam int IDLE_LIMIT    = 4000;
    localparam int DRAIN_CYCLES  = 120;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   chars_left;
    int   idle_cycles = 0;

    itf_in_if  in_ch();
    itf_out_if out_ch();

    integer_to_text_formatter_unit dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    itf_text_checker checker_u (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (in_ch),
        .i_out       (out_ch),
        .o_fail_count(fail_count),
        .o_chars_left(chars_left)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        rst_n <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send(logic [MODE_W-1:0] mode, logic [VALUE_W-1:0] value);
        in_ch.valid  <= 1'b1;
        in_ch.action <= mode;
        in_ch.value  <= value;
        do begin
            @(posedge clk);
        end while (!(in_ch.valid && in_ch.ready));
    endtask

    initial begin
        int seg;
        int style;
        int span;
        out_ch.ready <= 1'b0;
        seg = 0;
        @(posedge clk);
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            seg++;
            if (seg == HOLD_SEGMENT) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                style = $urandom_range(0, 3);
                span  = $urandom_range(4, 40);
                for (int k = 0; k < span; k++) begin
                    case (style)
                        0:       out_ch.ready <= 1'b1;
                        1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
                        2:       out_ch.ready <= ($urandom_range(0, 1) != 0);
                        default: out_ch.ready <= ($urandom_range(0, 4) == 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    initial begin
        int                  sent;
        int                  burst;
        int                  gap;
        logic [VALUE_W-1:0]  v;
        logic [MODE_W-1:0]   mode;
        in_ch.valid  <= 1'b0;
        in_ch.action <= '0;
        in_ch.value  <= '0;
        @(posedge clk);
        while (rst_n !== 1'b1) @(posedge clk);

        send(MODE_HEX, 64'h0);
        send(MODE_HEX, '1);
        send(MODE_HEX, 64'hf000_0000_0000_0000);
        send(MODE_HEX, 64'h1);
        send(MODE_HEX_PAD, 64'h0);
        send(MODE_HEX_PAD, '1);
        send(MODE_HEX_PAD, 64'h0123_4567_89ab_cdef);
        send(MODE_UDEC, 64'h0);
        send(MODE_UDEC, '1);
        send(MODE_UDEC, 64'd10);
        send(MODE_UDEC, 64'd9);
        send(MODE_SDEC, 64'h8000_0000_0000_0000);
        send(MODE_SDEC, '1);
        send(MODE_SDEC, 64'h7fff_ffff_ffff_ffff);
        send(MODE_SDEC, 64'h0);
        send(MODE_SDEC, 64'hffff_ffff_ffff_fff6);
        send(MODE_IPV4, 64'h0);
        send(MODE_IPV4, '1);
        send(MODE_IPV4, 64'hdead_beef_0a00_ff64);
        send(MODE_MAC, 64'h0);
        send(MODE_MAC, '1);
        send(MODE_MAC, 64'hffff_0f10_a009_00ff);
        send(MODE_SPARE_LO, 64'h0);
        send(MODE_SPARE_HI, '1);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 8);
            for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
                v = {$urandom, $urandom};
                case ($urandom_range(0, 4))
                    0:       v = v >> $urandom_range(0, 63);
                    1:       v = VALUE_W'($urandom_range(0, 999));
                    2:       v = v | 64'h8000_0000_0000_0000;
                    3:       v = v >> (DIGIT_W * $urandom_range(0, HEX_DIGITS - 1));
                    default: ;
                endcase
                mode = MODE_W'($urandom_range(0, 7));
                send(mode, v);
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap != 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end

        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (chars_left != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && chars_left == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
